/* rtl/kdlp_pkg.sv */
package kdlp_pkg;

    localparam int PORT_W     = 3;
    localparam int PIN_W      = 4;
    localparam int DEB_W      = 16;
    localparam int HOLD_W     = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_LIMIT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LEVEL     = 2'd2;

    localparam logic [DEB_W-1:0]  FILTER_LIMIT_RST     = 16'd10;
    localparam logic [HOLD_W-1:0] LONG_PRESS_LIMIT_RST = 24'd1000;
    localparam logic              ACTIVE_LEVEL_RST     = 1'b1;

    localparam logic [DEB_W-1:0]  DEB_MAX  = '1;
    localparam logic [HOLD_W-1:0] HOLD_MAX = '1;

    typedef enum logic [2:0] {
        PH_IDLE          = 3'd0,
        PH_PRESSING      = 3'd1,
        PH_SHORT_REL     = 3'd2,
        PH_LONG_PRESSING = 3'd3,
        PH_LONG_REL      = 3'd4
    } t_phase;

    typedef struct packed {
        logic [DEB_W-1:0]  filter_limit;
        logic [HOLD_W-1:0] long_press_limit;
        logic              active_level;
    } t_cfg;

    // classified sample, front to back
    typedef struct packed {
        logic              in_range;
        logic              active;
        logic [PORT_W-1:0] port;
        logic [PIN_W-1:0]  pin;
    } t_item;

    // per-key record
    typedef struct packed {
        t_phase            phase;
        logic [DEB_W-1:0]  deb;
        logic [HOLD_W-1:0] hold;
    } t_entry;

    typedef struct packed {
        t_phase            phase;
        logic [PORT_W-1:0] port;
        logic [PIN_W-1:0]  pin;
    } t_result;

endpackage

/* rtl/kdlp_fifo.sv */
module kdlp_fifo import kdlp_pkg::*; #(
    parameter int W          = 8,
    parameter int DEPTH_LOG2 = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    localparam int DEPTH = 1 << DEPTH_LOG2;

    logic [W-1:0]          r_mem [DEPTH];
    logic [DEPTH_LOG2-1:0] r_wptr, n_wptr;
    logic [DEPTH_LOG2-1:0] r_rptr, n_rptr;
    logic [DEPTH_LOG2:0]   r_count, n_count;
    logic                  wr, rd;

    assign o_full  = (r_count == (DEPTH_LOG2+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];

    assign wr = i_push && !o_full;
    assign rd = i_pop && !o_empty;

    always_comb begin
        n_wptr  = wr ? r_wptr + 1'b1 : r_wptr;
        n_rptr  = rd ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count;
        if (wr && !rd) begin
            n_count = r_count + 1'b1;
        end else if (rd && !wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

/* rtl/kdlp_front.sv */
module kdlp_front import kdlp_pkg::*; #(
    parameter int NUM_PORTS     = 5,
    parameter int PINS_PER_PORT = 16
) (
    input  logic [PORT_W-1:0] i_port_index,
    input  logic [PIN_W-1:0]  i_pin_number,
    input  logic              i_pin_level,
    input  logic              i_active_level,
    output t_item             o_item
);

    always_comb begin
        o_item.port     = i_port_index;
        o_item.pin      = i_pin_number;
        o_item.active   = (i_pin_level == i_active_level);
        o_item.in_range = (32'(i_port_index) < NUM_PORTS) &&
                          (32'(i_pin_number) < PINS_PER_PORT);
    end

endmodule

/* rtl/kdlp_back.sv */
module kdlp_back import kdlp_pkg::*; #(
    parameter int NUM_PORTS     = 5,
    parameter int PINS_PER_PORT = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    // classified item queue
    input  logic    i_item_empty,
    input  t_item   i_item,
    output logic    o_item_pop,
    // result queue
    input  logic    i_res_full,
    output logic    o_res_push,
    output t_result o_res
);

    localparam int KEYS = NUM_PORTS * PINS_PER_PORT;
    localparam int KW   = (KEYS > 1) ? $clog2(KEYS) : 1;

    t_entry          r_mem [KEYS];
    logic [KEYS-1:0] r_valid;

    logic            r_a_vld;
    t_item           r_item;
    logic [KW-1:0]   r_idx;
    t_entry          r_rd_q;
    logic            r_vb;
    logic            r_fwd;
    t_entry          r_fwd_entry;

    logic            load, fire, we;
    logic [KW-1:0]   ld_idx;
    t_entry          cur, w_entry;
    t_phase          n_phase;
    logic [DEB_W-1:0]  deb_inc;
    logic [HOLD_W-1:0] hold_inc;
    logic            deb_exc, hold_exc;

    assign fire       = r_a_vld && !i_res_full;
    assign load       = !i_item_empty && (!r_a_vld || fire);
    assign o_item_pop = load;
    assign we         = fire && r_item.in_range;

    assign ld_idx = i_item.in_range ?
                    KW'(32'(i_item.port) * PINS_PER_PORT + 32'(i_item.pin)) : '0;

    // a never-written key reads as idle with zero counts; the write in flight wins
    assign cur = r_fwd ? r_fwd_entry : (r_vb ? r_rd_q : '0);

    assign deb_inc  = (cur.deb == DEB_MAX) ? cur.deb : cur.deb + 1'b1;
    assign hold_inc = (cur.hold == HOLD_MAX) ? cur.hold : cur.hold + 1'b1;
    assign deb_exc  = cur.deb > i_cfg.filter_limit;
    assign hold_exc = cur.hold > i_cfg.long_press_limit;

    // next phase of the addressed key
    always_comb begin
        n_phase = PH_IDLE;
        unique case (cur.phase)
            PH_IDLE: begin
                n_phase = (r_item.active && deb_exc) ? PH_PRESSING : PH_IDLE;
            end
            PH_PRESSING: begin
                if (!r_item.active) begin
                    n_phase = deb_exc ? PH_SHORT_REL : PH_PRESSING;
                end else begin
                    n_phase = hold_exc ? PH_LONG_PRESSING : PH_PRESSING;
                end
            end
            PH_LONG_PRESSING: begin
                n_phase = (!r_item.active && deb_exc) ? PH_LONG_REL : PH_LONG_PRESSING;
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    // counter updates and record write-back
    always_comb begin
        w_entry       = cur;
        w_entry.phase = n_phase;
        unique case (cur.phase)
            PH_IDLE: begin
                if (r_item.active) begin
                    w_entry.deb = deb_exc ? '0 : deb_inc;
                end
            end
            PH_PRESSING: begin
                if (!r_item.active) begin
                    if (deb_exc) begin
                        w_entry.deb  = '0;
                        w_entry.hold = '0;
                    end else begin
                        w_entry.deb = deb_inc;
                    end
                end else begin
                    w_entry.hold = hold_exc ? '0 : hold_inc;
                end
            end
            PH_LONG_PRESSING: begin
                if (!r_item.active) begin
                    w_entry.deb = deb_exc ? '0 : deb_inc;
                end
            end
            default: ;
        endcase
    end

    assign o_res_push  = fire;
    assign o_res.phase = r_item.in_range ? n_phase : PH_IDLE;
    assign o_res.port  = r_item.port;
    assign o_res.pin   = r_item.pin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_valid <= '0;
        end else begin
            if (load) begin
                r_a_vld <= 1'b1;
            end else if (fire) begin
                r_a_vld <= 1'b0;
            end
            if (we) begin
                r_valid[r_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item      <= i_item;
            r_idx       <= ld_idx;
            r_vb        <= r_valid[ld_idx];
            r_fwd       <= we && (r_idx == ld_idx);
            r_fwd_entry <= w_entry;
        end
    end

    // key table: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[r_idx] <= w_entry;
        end
        if (load) begin
            r_rd_q <= r_mem[ld_idx];
        end
    end

endmodule

/* rtl/key_debounce_long_press_fsm.sv */
// Path: input queue, back end stage register, result queue (empty low shows the result).
// Throughput: one sample per cycle unless the result queue is full, set by the key table's
// separate read/write ports and forwarding of the same key's record written just before.
// Queues of four entries sit between input, back end and output.
// Reset: synchronous, active low; empties the queues, restores register defaults and
// marks every key record invalid (reads as idle, zero counts); no clearing pass.
module key_debounce_long_press_fsm import kdlp_pkg::*; #(
    parameter int NUM_PORTS     = 5,
    parameter int PINS_PER_PORT = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // sample input, queue style
    input  logic                  push,
    output logic                  full,
    input  logic [PORT_W-1:0]     i_port_index,
    input  logic [PIN_W-1:0]      i_pin_number,
    input  logic                  i_pin_level,
    // results, queue style
    output logic                  empty,
    input  logic                  pop,
    output logic [2:0]            o_key_state,
    output logic [PORT_W-1:0]     o_key_port,
    output logic [PIN_W-1:0]      o_key_pin,
    // register writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int QLOG2 = 2;

    t_cfg    r_cfg;
    t_item   front_item;
    t_item   mid_item;
    logic    mid_empty, mid_pop;
    logic    res_full, res_push;
    t_result res_in, res_out;

    // register file; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.filter_limit     <= FILTER_LIMIT_RST;
            r_cfg.long_press_limit <= LONG_PRESS_LIMIT_RST;
            r_cfg.active_level     <= ACTIVE_LEVEL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FILTER_LIMIT:     r_cfg.filter_limit     <= i_cfg_wdata[DEB_W-1:0];
                CFG_LONG_PRESS_LIMIT: r_cfg.long_press_limit <= i_cfg_wdata[HOLD_W-1:0];
                CFG_ACTIVE_LEVEL:     r_cfg.active_level     <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // front: range check and level compare
    kdlp_front #(
        .NUM_PORTS     (NUM_PORTS),
        .PINS_PER_PORT (PINS_PER_PORT)
    ) u_front (
        .i_port_index   (i_port_index),
        .i_pin_number   (i_pin_number),
        .i_pin_level    (i_pin_level),
        .i_active_level (r_cfg.active_level),
        .o_item         (front_item)
    );

    // classified samples waiting for the back end
    kdlp_fifo #(
        .W          ($bits(t_item)),
        .DEPTH_LOG2 (QLOG2)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_item),
        .o_full  (full),
        .i_pop   (mid_pop),
        .o_data  (mid_item),
        .o_empty (mid_empty)
    );

    // back: per-key record read-modify-write
    kdlp_back #(
        .NUM_PORTS     (NUM_PORTS),
        .PINS_PER_PORT (PINS_PER_PORT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item_empty (mid_empty),
        .i_item       (mid_item),
        .o_item_pop   (mid_pop),
        .i_res_full   (res_full),
        .o_res_push   (res_push),
        .o_res        (res_in)
    );

    // finished results
    kdlp_fifo #(
        .W          ($bits(t_result)),
        .DEPTH_LOG2 (QLOG2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_key_state = res_out.phase;
    assign o_key_port  = res_out.port;
    assign o_key_pin   = res_out.pin;

    // back end never transfers into a full result queue
    a_no_res_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("result pushed into full queue");

    // back end only pops classified items that exist
    a_no_mid_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mid_pop |-> !mid_empty)
        else $error("item popped from empty queue");

    // a key outside the array always reports idle
    a_out_of_range_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (32'(o_key_port) >= NUM_PORTS || 32'(o_key_pin) >= PINS_PER_PORT))
        |-> (o_key_state == PH_IDLE))
        else $error("out of range key reported non-idle state");

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result pending after reset");

endmodule
